// ===== design/assert_macros.svh =====
// Assertion macros shared by the design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition implies a consequence at the same clock edge.
`define ASSERT_SAME(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (cons)) \
        else $error("assertion failed");

// Checks that a condition implies a consequence at the next clock edge.
`define ASSERT_NEXT(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== design/wsfd_pkg.sv =====
// Types, constants and the direction table of the weather sensor frame decoder.
package wsfd_pkg;

    localparam int STORE_DEPTH = 9;
    localparam int CNT_W = 4;
    localparam int SUM_W = 12;

    localparam logic [2:0] KIND_BAD_LEN   = 3'd0;
    localparam logic [2:0] KIND_BAD_SUM   = 3'd1;
    localparam logic [2:0] KIND_TOWER     = 3'd2;
    localparam logic [2:0] KIND_WIND_RAIN = 3'd3;
    localparam logic [2:0] KIND_WIND_TEMP = 3'd4;
    localparam logic [2:0] KIND_UNKNOWN   = 3'd5;
    localparam logic [2:0] KIND_UNDECODED = 3'd6;

    localparam logic [5:0] TYPE_WIND_RAIN = 6'h31;
    localparam logic [5:0] TYPE_WIND_TEMP = 6'h38;

    localparam logic [7:0] BITS_MIN = 8'd56;
    localparam logic [7:0] BITS_MAX = 8'd65;
    localparam logic [7:0] BITS_SEVEN_BYTES = 8'd56;
    localparam logic [7:0] BITS_EIGHT_BYTES = 8'd64;

    localparam logic [14:0] TOWER_TEMP_OFS   = 15'd1000;
    localparam logic [14:0] STATION_TEMP_OFS = 15'd400;

    typedef logic [STORE_DEPTH-1:0][7:0] t_row_bytes;
    typedef logic [STORE_DEPTH-1:0][SUM_W-1:0] t_row_sums;

    typedef struct packed {
        logic             valid;
        logic [CNT_W-1:0] count;
        logic [7:0]       bits;
    } t_pend;

    typedef struct packed {
        logic [2:0]  frame_kind;
        logic [1:0]  channel_code;
        logic [13:0] node_id;
        logic [5:0]  msg_code;
        logic [7:0]  status_byte;
        logic [6:0]  humidity;
        logic [14:0] temp_tenths;
        logic [7:0]  wind_rate;
        logic [3:0]  wind_dir_index;
        logic [11:0] wind_dir_tenths;
        logic [13:0] rain_counter;
        logic [14:0] rain_delta;
    } t_result;

    function automatic logic [11:0] dir_tenths(input logic [3:0] code);
        logic [11:0] v;
        case (code)
            4'd0:    v = 12'd3150;
            4'd1:    v = 12'd2475;
            4'd2:    v = 12'd2925;
            4'd3:    v = 12'd2700;
            4'd4:    v = 12'd3375;
            4'd5:    v = 12'd2250;
            4'd6:    v = 12'd0;
            4'd7:    v = 12'd2025;
            4'd8:    v = 12'd675;
            4'd9:    v = 12'd1350;
            4'd10:   v = 12'd900;
            4'd11:   v = 12'd1125;
            4'd12:   v = 12'd450;
            4'd13:   v = 12'd1575;
            4'd14:   v = 12'd225;
            default: v = 12'd1800;
        endcase
        return v;
    endfunction

endpackage

// ===== design/weather_sensor_frame_decoder.sv =====
// Top level of the weather sensor frame decoder with its output register.
// The slave channel takes one row byte per item in i_s_tdata[7:0]; the item
// that carries i_s_tlast ends the row and also carries the row bit count in
// i_s_tdata[15:8]. Each row end yields exactly one result item on the master
// channel, with the frame kind in o_m_tuser and the decoded fields in
// o_m_tdata; fields that the kind does not report are zero.
// A byte is stored in the cycle it is accepted while the store has room. The
// row end is held in a pending register, then decoded and loaded into the
// output register once that register is empty or being taken. One item is
// accepted in every cycle while o_s_tready is high; the store, the pending
// register and the output register each hold one entry.
// Reset clears the byte count, the pending row end, the output valid flag
// and the rain baseline.
// When the receiver stalls with a result waiting and another row end is
// pending, o_s_tready drops until the output register is taken.
`include "assert_macros.svh"

module weather_sensor_frame_decoder (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [15:0]  i_s_tdata,   // data_byte[7:0], row_bits[15:8]
    input  logic         i_s_tlast,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // channel_code[1:0], node_id[15:2], msg_code[21:16], status_byte[29:22],
    // humidity[36:30], temp_tenths[51:37], wind_rate[59:52],
    // wind_dir_index[63:60], wind_dir_tenths[75:64], rain_counter[89:76],
    // rain_delta[104:90], zero fill[111:105]
    output logic [111:0] o_m_tdata,
    output logic [2:0]   o_m_tuser    // frame_kind[2:0]
);

    wsfd_pkg::t_row_bytes row_bytes;
    wsfd_pkg::t_row_sums  row_sums;
    wsfd_pkg::t_pend      pend;
    wsfd_pkg::t_result    result;
    wsfd_pkg::t_result    r_out;
    logic                 r_out_valid;
    logic                 s_accept;
    logic                 take;

    assign o_s_tready = !(pend.valid && r_out_valid && !i_m_tready);
    assign s_accept   = i_s_tvalid && o_s_tready;
    assign take       = pend.valid && (!r_out_valid || i_m_tready);

    wsfd_rowbuf u_rowbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (s_accept),
        .i_data  (i_s_tdata[7:0]),
        .i_last  (i_s_tlast),
        .i_bits  (i_s_tdata[15:8]),
        .i_take  (take),
        .o_bytes (row_bytes),
        .o_sums  (row_sums),
        .o_pend  (pend)
    );

    wsfd_decode u_decode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_bytes  (row_bytes),
        .i_sums   (row_sums),
        .i_count  (pend.count),
        .i_bits   (pend.bits),
        .i_commit (take),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out <= result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out.frame_kind;
    assign o_m_tdata  = {7'd0, r_out.rain_delta, r_out.rain_counter,
                         r_out.wind_dir_tenths, r_out.wind_dir_index, r_out.wind_rate,
                         r_out.temp_tenths, r_out.humidity, r_out.status_byte,
                         r_out.msg_code, r_out.node_id, r_out.channel_code};

    `ASSERT_SAME(a_stall_blocks_input, i_clk, i_rst_n,
        pend.valid && r_out_valid && !i_m_tready, !o_s_tready)
    `ASSERT_NEXT(a_row_end_pends, i_clk, i_rst_n, s_accept && i_s_tlast, pend.valid)
    `ASSERT_SAME(a_bad_len_clean, i_clk, i_rst_n,
        o_m_tvalid && (o_m_tuser == wsfd_pkg::KIND_BAD_LEN), o_m_tdata == '0)
    `ASSERT_NEXT(a_take_shows_result, i_clk, i_rst_n, take, o_m_tvalid)

endmodule

// ===== design/wsfd_rowbuf.sv =====
// Row byte store with running checksums and the pending-decode register.
module wsfd_rowbuf (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_wr,
    input  logic [7:0]            i_data,
    input  logic                  i_last,
    input  logic [7:0]            i_bits,
    input  logic                  i_take,
    output wsfd_pkg::t_row_bytes  o_bytes,
    output wsfd_pkg::t_row_sums   o_sums,
    output wsfd_pkg::t_pend       o_pend
);

    localparam logic [wsfd_pkg::CNT_W-1:0] DEPTH_CNT = wsfd_pkg::CNT_W'(wsfd_pkg::STORE_DEPTH);

    wsfd_pkg::t_row_bytes r_bytes;
    wsfd_pkg::t_row_sums  r_sums;
    logic [wsfd_pkg::CNT_W-1:0] r_count;
    logic [wsfd_pkg::CNT_W-1:0] n_count;
    logic [wsfd_pkg::CNT_W-1:0] row_count;
    logic [wsfd_pkg::SUM_W-1:0] prev_sum;
    logic [wsfd_pkg::SUM_W-1:0] new_sum;
    logic                       room;
    logic                       r_pend_valid;
    logic [wsfd_pkg::CNT_W-1:0] r_pend_count;
    logic [7:0]                 r_pend_bits;

    assign room = r_count < DEPTH_CNT;
    assign row_count = room ? r_count + 1'b1 : r_count;
    assign n_count = i_last ? '0 : row_count;

    always_comb begin
        prev_sum = '0;
        for (int i = 0; i < wsfd_pkg::STORE_DEPTH - 1; i++) begin
            if (r_count == wsfd_pkg::CNT_W'(i + 1)) begin
                prev_sum = r_sums[i];
            end
        end
    end

    assign new_sum = prev_sum + wsfd_pkg::SUM_W'(i_data);

    always_ff @(posedge i_clk) begin
        if (i_wr && room) begin
            for (int i = 0; i < wsfd_pkg::STORE_DEPTH; i++) begin
                if (r_count == wsfd_pkg::CNT_W'(i)) begin
                    r_bytes[i] <= i_data;
                    r_sums[i]  <= new_sum;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_pend_valid <= 1'b0;
        end else begin
            if (i_wr) begin
                r_count <= n_count;
            end
            if (i_wr && i_last) begin
                r_pend_valid <= 1'b1;
            end else if (i_take) begin
                r_pend_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr && i_last) begin
            r_pend_count <= row_count;
            r_pend_bits  <= i_bits;
        end
    end

    assign o_bytes = r_bytes;
    assign o_sums  = r_sums;
    assign o_pend  = {r_pend_valid, r_pend_count, r_pend_bits};

endmodule

// ===== design/wsfd_decode.sv =====
// Frame decode of a finished row and the rain counter baseline.
module wsfd_decode (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  wsfd_pkg::t_row_bytes        i_bytes,
    input  wsfd_pkg::t_row_sums         i_sums,
    input  logic [wsfd_pkg::CNT_W-1:0]  i_count,
    input  logic [7:0]                  i_bits,
    input  logic                        i_commit,
    output wsfd_pkg::t_result           o_result
);

    wsfd_pkg::t_row_bytes       rdv;
    logic                       len_ok;
    logic [wsfd_pkg::CNT_W-1:0] n0;
    logic [wsfd_pkg::CNT_W-1:0] n;
    logic [wsfd_pkg::CNT_W-1:0] m;
    logic [7:0]                 last0;
    logic [7:0]                 chk;
    logic [wsfd_pkg::SUM_W-1:0] sum;
    logic [13:0]                tower_raw;
    logic [10:0]                station_raw;
    logic [13:0]                rain_cnt;
    logic [7:0]                 speed;
    logic [13:0]                r_base;
    logic [13:0]                n_base;
    wsfd_pkg::t_result          res;

    always_comb begin
        for (int i = 0; i < wsfd_pkg::STORE_DEPTH; i++) begin
            rdv[i] = (wsfd_pkg::CNT_W'(i) < i_count) ? i_bytes[i] : 8'd0;
        end
    end

    assign len_ok = (i_bits >= wsfd_pkg::BITS_MIN) && (i_bits <= wsfd_pkg::BITS_MAX);

    always_comb begin
        if (i_bits <= wsfd_pkg::BITS_SEVEN_BYTES) begin
            n0 = 4'd7;
        end else if (i_bits <= wsfd_pkg::BITS_EIGHT_BYTES) begin
            n0 = 4'd8;
        end else begin
            n0 = 4'd9;
        end
        case (n0)
            4'd7:    last0 = rdv[6];
            4'd8:    last0 = rdv[7];
            default: last0 = rdv[8];
        endcase
        n = (last0 == 8'd0) ? n0 - 1'b1 : n0;
        case (n)
            4'd6:    chk = rdv[5];
            4'd7:    chk = rdv[6];
            4'd8:    chk = rdv[7];
            default: chk = rdv[8];
        endcase
        m = ((n - 1'b1) < i_count) ? n - 1'b1 : i_count;
        sum = '0;
        for (int k = 1; k <= wsfd_pkg::STORE_DEPTH; k++) begin
            if (m == wsfd_pkg::CNT_W'(k)) begin
                sum = i_sums[k-1];
            end
        end
    end

    assign tower_raw   = {rdv[4][6:0], rdv[5][6:0]};
    assign station_raw = {rdv[4][3:0], rdv[5][6:0]};
    assign rain_cnt    = {rdv[5][6:0], rdv[6][6:0]};
    assign speed       = {rdv[3][4:0], rdv[4][6:4]};

    always_comb begin
        res    = '0;
        n_base = r_base;
        if (!len_ok) begin
            res.frame_kind = wsfd_pkg::KIND_BAD_LEN;
        end else if ((sum == '0) || (sum[7:0] != chk)) begin
            res.frame_kind = wsfd_pkg::KIND_BAD_SUM;
        end else if (n == 4'd7) begin
            res.frame_kind   = wsfd_pkg::KIND_TOWER;
            res.channel_code = rdv[0][7:6];
            res.node_id      = {rdv[0][5:0], rdv[1]};
            res.status_byte  = rdv[2];
            res.humidity     = rdv[3][6:0];
            res.temp_tenths  = {1'b0, tower_raw} - wsfd_pkg::TOWER_TEMP_OFS;
        end else if (n != 4'd8) begin
            res.frame_kind = wsfd_pkg::KIND_UNDECODED;
        end else begin
            res.channel_code = rdv[0][7:6];
            res.node_id      = {2'b00, rdv[0][3:0], rdv[1]};
            res.msg_code     = rdv[2][5:0];
            if (rdv[2][5:0] == wsfd_pkg::TYPE_WIND_RAIN) begin
                res.frame_kind      = wsfd_pkg::KIND_WIND_RAIN;
                res.wind_rate       = speed;
                res.wind_dir_index  = rdv[4][3:0];
                res.wind_dir_tenths = wsfd_pkg::dir_tenths(rdv[4][3:0]);
                res.rain_counter    = rain_cnt;
                if (r_base != 14'd0) begin
                    res.rain_delta = {1'b0, rain_cnt} - {1'b0, r_base};
                    if (rain_cnt < r_base) begin
                        n_base = rain_cnt;
                    end
                end else begin
                    n_base = rain_cnt;
                end
            end else if (rdv[2][5:0] == wsfd_pkg::TYPE_WIND_TEMP) begin
                res.frame_kind  = wsfd_pkg::KIND_WIND_TEMP;
                res.wind_rate   = speed;
                res.temp_tenths = {4'd0, station_raw} - wsfd_pkg::STATION_TEMP_OFS;
                res.humidity    = rdv[6][6:0];
            end else begin
                res.frame_kind  = wsfd_pkg::KIND_UNKNOWN;
                res.status_byte = rdv[3];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= '0;
        end else if (i_commit) begin
            r_base <= n_base;
        end
    end

    assign o_result = res;

endmodule

// ===== test/wsfd_result_checker.sv =====
// Checker that predicts every decoded frame of the decoder and compares it with the output.
module wsfd_result_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    input  logic         i_s_tready,
    input  logic [15:0]  i_s_tdata,   // data_byte[7:0], row_bits[15:8]
    input  logic         i_s_tlast,
    input  logic         i_m_tvalid,
    input  logic         i_m_tready,
    // channel_code[1:0], node_id[15:2], msg_code[21:16], status_byte[29:22],
    // humidity[36:30], temp_tenths[51:37], wind_rate[59:52],
    // wind_dir_index[63:60], wind_dir_tenths[75:64], rain_counter[89:76],
    // rain_delta[104:90], zero fill[111:105]
    input  logic [111:0] i_m_tdata,
    input  logic [2:0]   i_m_tuser,   // frame_kind[2:0]
    output int           o_errors,
    output int           o_pending
);

    localparam int REPORT_LIMIT = 10;
    localparam logic [11:0] DIR_DECI [16] = '{
        12'd3150, 12'd2475, 12'd2925, 12'd2700, 12'd3375, 12'd2250, 12'd0,    12'd2025,
        12'd675,  12'd1350, 12'd900,  12'd1125, 12'd450,  12'd1575, 12'd225,  12'd1800
    };

    logic [7:0]         row_bytes [wsfd_pkg::STORE_DEPTH];
    int                 row_len;
    logic [13:0]        rain_base;
    wsfd_pkg::t_result  frame_q [$];
    int                 mismatches;

    function automatic logic [7:0] row_at(input int idx);
        if (idx < row_len && idx < wsfd_pkg::STORE_DEPTH) begin
            return row_bytes[idx];
        end
        return 8'd0;
    endfunction

    task automatic decode_row(input logic [7:0] bits, output wsfd_pkg::t_result res);
        int          n;
        logic [31:0] total;
        logic [13:0] count14;
        logic [7:0]  rb [wsfd_pkg::STORE_DEPTH];
        res = '0;
        for (int k = 0; k < wsfd_pkg::STORE_DEPTH; k++) begin
            rb[k] = row_at(k);
        end
        if (bits < wsfd_pkg::BITS_MIN || bits > wsfd_pkg::BITS_MAX) begin
            res.frame_kind = wsfd_pkg::KIND_BAD_LEN;
            return;
        end
        n = (int'(bits) + 7) / 8;
        if (rb[n - 1] == 8'd0) begin
            n--;
        end
        total = '0;
        for (int k = 0; k + 1 < n; k++) begin
            total += 32'(rb[k]);
        end
        if (total == 32'd0 || total[7:0] != rb[n - 1]) begin
            res.frame_kind = wsfd_pkg::KIND_BAD_SUM;
            return;
        end
        if (n == 7) begin
            res.frame_kind   = wsfd_pkg::KIND_TOWER;
            res.channel_code = rb[0][7:6];
            res.node_id      = {rb[0][5:0], rb[1]};
            res.status_byte  = rb[2];
            res.humidity     = rb[3][6:0];
            res.temp_tenths  = 15'({rb[4][6:0], rb[5][6:0]}) - wsfd_pkg::TOWER_TEMP_OFS;
            return;
        end
        if (n != 8) begin
            res.frame_kind = wsfd_pkg::KIND_UNDECODED;
            return;
        end
        res.channel_code = rb[0][7:6];
        res.node_id      = {2'b00, rb[0][3:0], rb[1]};
        res.msg_code     = rb[2][5:0];
        case (res.msg_code)
            wsfd_pkg::TYPE_WIND_RAIN: begin
                count14              = {rb[5][6:0], rb[6][6:0]};
                res.frame_kind       = wsfd_pkg::KIND_WIND_RAIN;
                res.wind_rate        = {rb[3][4:0], rb[4][6:4]};
                res.wind_dir_index   = rb[4][3:0];
                res.wind_dir_tenths  = DIR_DECI[rb[4][3:0]];
                res.rain_counter     = count14;
                // A zero baseline means none was captured yet.
                if (rain_base != 14'd0) begin
                    res.rain_delta = 15'(count14) - 15'(rain_base);
                    if (count14 < rain_base) begin
                        rain_base = count14;
                    end
                end else begin
                    rain_base = count14;
                end
            end
            wsfd_pkg::TYPE_WIND_TEMP: begin
                res.frame_kind  = wsfd_pkg::KIND_WIND_TEMP;
                res.wind_rate   = {rb[3][4:0], rb[4][6:4]};
                res.temp_tenths = 15'({rb[4][3:0], rb[5][6:0]}) - wsfd_pkg::STATION_TEMP_OFS;
                res.humidity    = rb[6][6:0];
            end
            default: begin
                res.frame_kind  = wsfd_pkg::KIND_UNKNOWN;
                res.status_byte = rb[3];
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
                $display("mismatch in %s: expected %0h, got %0h", name, want, got);
            end
        end
    endtask

    always @(posedge i_clk) begin : watch
        wsfd_pkg::t_result want;
        wsfd_pkg::t_result seen;
        if (!i_rst_n) begin
            row_len   = 0;
            rain_base = '0;
            frame_q.delete();
            mismatches = 0;
            o_errors  <= 0;
            o_pending <= 0;
        end else begin
            if (i_s_tvalid && i_s_tready) begin
                if (row_len < wsfd_pkg::STORE_DEPTH) begin
                    row_bytes[row_len] = i_s_tdata[7:0];
                    row_len++;
                end
                if (i_s_tlast) begin
                    decode_row(i_s_tdata[15:8], want);
                    frame_q.push_back(want);
                    row_len = 0;
                end
            end
            if (i_m_tvalid && i_m_tready) begin
                seen.frame_kind      = i_m_tuser;
                seen.channel_code    = i_m_tdata[1:0];
                seen.node_id         = i_m_tdata[15:2];
                seen.msg_code        = i_m_tdata[21:16];
                seen.status_byte     = i_m_tdata[29:22];
                seen.humidity        = i_m_tdata[36:30];
                seen.temp_tenths     = i_m_tdata[51:37];
                seen.wind_rate       = i_m_tdata[59:52];
                seen.wind_dir_index  = i_m_tdata[63:60];
                seen.wind_dir_tenths = i_m_tdata[75:64];
                seen.rain_counter    = i_m_tdata[89:76];
                seen.rain_delta      = i_m_tdata[104:90];
                if (frame_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT) begin
                        $display("result item with none expected: kind %0d, data %0h",
                                 i_m_tuser, i_m_tdata);
                    end
                end else begin
                    want = frame_q.pop_front();
                    check_field("frame_kind", 16'(want.frame_kind), 16'(seen.frame_kind));
                    check_field("channel_code", 16'(want.channel_code),
                                16'(seen.channel_code));
                    check_field("node_id", 16'(want.node_id), 16'(seen.node_id));
                    check_field("msg_code", 16'(want.msg_code), 16'(seen.msg_code));
                    check_field("status_byte", 16'(want.status_byte), 16'(seen.status_byte));
                    check_field("humidity", 16'(want.humidity), 16'(seen.humidity));
                    check_field("temp_tenths", 16'(want.temp_tenths), 16'(seen.temp_tenths));
                    check_field("wind_rate", 16'(want.wind_rate), 16'(seen.wind_rate));
                    check_field("wind_dir_index", 16'(want.wind_dir_index),
                                16'(seen.wind_dir_index));
                    check_field("wind_dir_tenths", 16'(want.wind_dir_tenths),
                                16'(seen.wind_dir_tenths));
                    check_field("rain_counter", 16'(want.rain_counter),
                                16'(seen.rain_counter));
                    check_field("rain_delta", 16'(want.rain_delta), 16'(seen.rain_delta));
                    check_field("zero fill", 16'd0, 16'(i_m_tdata[111:105]));
                end
            end
            o_errors  <= mismatches;
            o_pending <= frame_q.size();
        end
    end

endmodule

// ===== test/weather_sensor_frame_decoder_tb.sv =====
// Testbench top of the weather sensor frame decoder: row stimulus, flow control and verdict.
module weather_sensor_frame_decoder_tb;

    typedef logic [7:0] t_byte_q [$];

    localparam int ITEM_TARGET  = 850;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;
    localparam int LONG_HOLD    = 300;

    logic         i_clk      = 1'b0;
    logic         i_rst_n    = 1'b0;
    logic         i_s_tvalid = 1'b0;
    logic [15:0]  i_s_tdata  = '0;    // data_byte[7:0], row_bits[15:8]
    logic         i_s_tlast  = 1'b0;
    logic         i_m_tready = 1'b0;
    logic         o_s_tready;
    logic         o_m_tvalid;
    logic [111:0] o_m_tdata;
    logic [2:0]   o_m_tuser;          // frame_kind[2:0]

    int           fail_count;
    int           open_count;
    int           cycle_count   = 0;
    int           sent_items    = 0;
    int           results_taken = 0;
    int           tx_calm       = 0;
    int           rx_calm       = 0;
    logic [13:0]  rain_now      = 14'd100;

    weather_sensor_frame_decoder dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    wsfd_result_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .i_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_m_tdata  (o_m_tdata),
        .i_m_tuser  (o_m_tuser),
        .o_errors   (fail_count),
        .o_pending  (open_count)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic t_byte_q sealed(input t_byte_q b);
        logic [7:0] sum;
        sum = '0;
        foreach (b[k]) begin
            sum += b[k];
        end
        b.push_back(sum);
        return b;
    endfunction

    function automatic t_byte_q tower_bytes(input logic [13:0] raw);
        t_byte_q b;
        repeat (6) b.push_back(8'($urandom));
        b[4][6:0] = raw[13:7];
        b[5][6:0] = raw[6:0];
        return sealed(b);
    endfunction

    function automatic t_byte_q station_bytes(input logic [7:0] b2, input logic [7:0] b4,
                                              input logic [7:0] b5, input logic [7:0] b6);
        t_byte_q b;
        repeat (7) b.push_back(8'($urandom));
        b[2] = b2;
        b[4] = b4;
        b[5] = b5;
        b[6] = b6;
        return sealed(b);
    endfunction

    function automatic t_byte_q rain_bytes(input logic [13:0] cnt);
        return station_bytes({2'($urandom), wsfd_pkg::TYPE_WIND_RAIN}, 8'($urandom),
                             {1'($urandom), cnt[13:7]}, {1'($urandom), cnt[6:0]});
    endfunction

    // Either side may idle before each item, with occasional runs without gaps.
    task automatic pick_gap(inout int calm, output int gap);
        if (calm > 0) begin
            calm--;
            gap = 0;
        end else if ($urandom_range(0, 15) == 0) begin
            calm = $urandom_range(10, 30);
            gap = 0;
        end else begin
            gap = $urandom_range(0, 9);
        end
    endtask

    task automatic send_byte(input logic [7:0] data, input logic last, input logic [7:0] bits);
        int gap;
        pick_gap(tx_calm, gap);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {(last ? bits : 8'($urandom)), data};
        i_s_tlast  <= last;
        do @(posedge i_clk); while (!o_s_tready);
        sent_items++;
    endtask

    task automatic send_row(input t_byte_q b, input logic [7:0] bits);
        foreach (b[k]) begin
            send_byte(b[k], k == b.size() - 1, bits);
        end
    endtask

    initial begin : drive_rows
        t_byte_q    row;
        logic [7:0] bits;
        logic [5:0] code;
        int         pick;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Tower temperature extremes, then a tower row with a trailing zero byte.
        send_row(tower_bytes(14'd0), wsfd_pkg::BITS_SEVEN_BYTES);
        send_row(tower_bytes(14'h3fff), wsfd_pkg::BITS_SEVEN_BYTES);
        row = tower_bytes(14'($urandom));
        row.push_back(8'h00);
        send_row(row, 8'd60);
        // Bit counts just outside the accepted range and at the field extremes.
        send_row(tower_bytes(14'($urandom)), 8'd55);
        send_row(station_bytes(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom)),
                 8'd66);
        row.delete();
        row.push_back(8'hff);
        send_row(row, 8'hff);
        // Rain baseline is captured, then gives a delta, then follows the counter down.
        send_row(rain_bytes(14'd300), wsfd_pkg::BITS_EIGHT_BYTES);
        send_row(rain_bytes(14'h3fff), wsfd_pkg::BITS_EIGHT_BYTES);
        send_row(rain_bytes(14'd5), wsfd_pkg::BITS_EIGHT_BYTES);
        // Station temperature extremes, the second one with a trimmed ninth byte.
        send_row(station_bytes({2'b00, wsfd_pkg::TYPE_WIND_TEMP}, 8'h00, 8'h00, 8'h7f),
                 wsfd_pkg::BITS_EIGHT_BYTES);
        row = station_bytes({2'b11, wsfd_pkg::TYPE_WIND_TEMP}, 8'hff, 8'hff, 8'h00);
        row.push_back(8'h00);
        send_row(row, wsfd_pkg::BITS_MAX);
        send_row(station_bytes(8'hff, 8'($urandom), 8'($urandom), 8'($urandom)),
                 wsfd_pkg::BITS_EIGHT_BYTES);
        // A good nine byte row and a good six byte row cannot be decoded.
        row.delete();
        repeat (8) row.push_back(8'h11);
        send_row(sealed(row), wsfd_pkg::BITS_MAX);
        row.delete();
        for (int k = 1; k <= 5; k++) begin
            row.push_back(8'(k));
        end
        row = sealed(row);
        row.push_back(8'h00);
        send_row(row, wsfd_pkg::BITS_SEVEN_BYTES);
        // Broken checksum, all zero row, overlong row and short row.
        row = tower_bytes(14'($urandom));
        row[6] ^= 8'h01;
        send_row(row, wsfd_pkg::BITS_SEVEN_BYTES);
        row.delete();
        repeat (7) row.push_back(8'h00);
        send_row(row, wsfd_pkg::BITS_SEVEN_BYTES);
        row.delete();
        repeat (12) row.push_back(8'($urandom));
        send_row(row, wsfd_pkg::BITS_EIGHT_BYTES);
        row.delete();
        repeat (3) row.push_back(8'($urandom));
        send_row(row, wsfd_pkg::BITS_EIGHT_BYTES);

        while (sent_items < ITEM_TARGET) begin
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                row = tower_bytes(14'($urandom));
                if ($urandom_range(0, 3) == 0) begin
                    row.push_back(8'h00);
                    bits = 8'($urandom_range(57, 64));
                end else begin
                    bits = wsfd_pkg::BITS_SEVEN_BYTES;
                end
            end else if (pick < 90) begin
                case ($urandom_range(0, 4))
                    0, 1:    code = wsfd_pkg::TYPE_WIND_RAIN;
                    2, 3:    code = wsfd_pkg::TYPE_WIND_TEMP;
                    default: code = 6'($urandom);
                endcase
                if (code == wsfd_pkg::TYPE_WIND_RAIN) begin
                    case ($urandom_range(0, 19)) inside
                        [0:13]:  rain_now += 14'($urandom_range(0, 25));
                        [14:16]: rain_now -= 14'($urandom_range(1, 60));
                        [17:18]: rain_now = 14'($urandom);
                        default: rain_now = 14'd0;
                    endcase
                    row = rain_bytes(rain_now);
                end else begin
                    row = station_bytes({2'($urandom), code}, 8'($urandom), 8'($urandom),
                                        8'($urandom));
                end
                if ($urandom_range(0, 3) == 0) begin
                    row.push_back(8'h00);
                    bits = wsfd_pkg::BITS_MAX;
                end else begin
                    bits = 8'($urandom_range(57, 64));
                end
                // Some well-formed rows get one bit flipped.
                if (pick >= 80) begin
                    row[$urandom_range(0, 7)] ^= 8'(1 << $urandom_range(0, 7));
                end
            end else begin
                row.delete();
                repeat ($urandom_range(1, 12)) row.push_back(8'($urandom));
                bits = $urandom_range(0, 1) ? 8'($urandom) : 8'($urandom_range(54, 67));
            end
            send_row(row, bits);
        end
        i_s_tvalid <= 1'b0;

        @(posedge i_clk);
        while (open_count != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && open_count == 0) begin
            $display("weather_sensor_frame_decoder_tb: done, clean");
        end else begin
            $display("weather_sensor_frame_decoder_tb: done, errors");
        end
        $finish;
    end

    // The receiver holds off twice for a long stretch so that the decoder stalls its input.
    initial begin : take_results
        int gap;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (results_taken == 20 || results_taken == 70) begin
                gap = LONG_HOLD;
            end else begin
                pick_gap(rx_calm, gap);
            end
            if (gap > 0) begin
                i_m_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_tvalid);
            results_taken++;
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("weather_sensor_frame_decoder_tb: done, errors");
        $finish;
    end

endmodule
